/* rtl/core/tlpjq_pkg.sv */
`default_nettype none

package tlpjq_pkg;

  // operation carried by an input item
  typedef enum logic [1:0] {
    MODE_PUSH   = 2'd0,
    MODE_TAKE   = 2'd1,
    MODE_FINISH = 2'd2,
    MODE_QUERY  = 2'd3
  } mode_t;

  // result status
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // priority levels, also the index of each fifo
  typedef enum logic [1:0] {
    LVL_LOW    = 2'd0,
    LVL_NORMAL = 2'd1,
    LVL_HIGH   = 2'd2
  } level_t;

  localparam int unsigned NUM_LEVELS = 3;

endpackage

`default_nettype wire

/* rtl/core/three_level_priority_job_queue.sv */
// three-level strict priority job queue
//
// input channel (s_*): one item per operation; s_tuser carries the operation
// (push, take, mark finished, query finished), s_tdata the job id, the push
// priority and the take ceiling. output channel (m_*): exactly one result
// item per input item, in order, with status, taken job, its level and the
// query answer.
// path: an accepted item sits in the input register, then its result in the
// result register, from which it is offered.
// throughput: one item per cycle unless m_tready or the bitmap clear stalls;
// push and take only touch the head and count registers and one port of
// the shared fifo memory, so nothing loops. reset: heads and counts clear at
// once; then the finished-job bitmap is swept clean, one entry a cycle, all
// 2**ID_BITS entries (256 with the default ID_BITS); s_tready is low throughout.
// receiver stall: the result register holds its item and the input register
// still takes one more item; after that s_tready drops until m_tready returns.
`default_nettype none

module three_level_priority_job_queue #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned ID_BITS     = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // [7:0] job_id, [9:8] priority_req, [11:10] max_priority, [15:12] zero
  input  wire logic [15:0] s_tdata,
  // [1:0] mode
  input  wire logic [1:0]  s_tuser,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // [1:0] status, [2] job_valid, [10:3] job_out, [12:11] job_level,
  // [13] is_finished, [15:14] zero
  output logic [15:0]      m_tdata
);

  localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned SW = PW + 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned AW = $clog2(tlpjq_pkg::NUM_LEVELS * QUEUE_DEPTH);
  localparam int unsigned MEM_DEPTH = tlpjq_pkg::NUM_LEVELS * QUEUE_DEPTH;
  localparam int unsigned ID_COUNT = 2 ** ID_BITS;

  // input register
  logic             in_valid;
  tlpjq_pkg::mode_t in_mode;
  logic [7:0]       in_job;
  logic [1:0]       in_prio;
  logic [1:0]       in_ceil;

  // fifo bookkeeping, one entry per level
  logic [PW-1:0] head [tlpjq_pkg::NUM_LEVELS];
  logic [CW-1:0] cnt  [tlpjq_pkg::NUM_LEVELS];

  // shared storage of the three fifos and the finished-job bitmap
  logic [ID_BITS-1:0] queue_mem [MEM_DEPTH];
  logic               done_mem  [ID_COUNT];

  // bitmap clearing pass after reset
  logic               clr_busy;
  logic [ID_BITS-1:0] clr_idx;

  // result register
  logic                 out_valid;
  tlpjq_pkg::status_t   o_status;
  logic                 o_hit;
  logic [1:0]           o_level;
  logic                 o_qry;
  logic [ID_BITS-1:0]   job_rd;
  logic                 fin_rd;

  // decode of the item in the input register
  logic                 fire;
  logic [ID_BITS+7:0]   id_wide;
  logic [ID_BITS-1:0]   id;
  logic [1:0]           push_lv;
  logic                 push_full;
  logic [SW-1:0]        tail_sum;
  logic [PW-1:0]        tail_pos;
  logic                 take_hit;
  logic [1:0]           take_lv;
  logic [PW-1:0]        head_next;
  logic                 is_push;
  logic                 is_take;
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [AW-1:0]        rd_addr;
  logic [ID_BITS+7:0]   job_wide;

  assign fire     = in_valid && (!out_valid || m_tready);
  assign s_tready = !clr_busy && (!in_valid || fire);
  assign is_push  = (in_mode == tlpjq_pkg::MODE_PUSH);
  assign is_take  = (in_mode == tlpjq_pkg::MODE_TAKE);

  always_comb begin
    // ids above ID_BITS are dropped, narrow ids are zero extended
    id_wide = {{ID_BITS{1'b0}}, in_job};
    id      = id_wide[ID_BITS-1:0];

    // unknown priorities fall into the low fifo
    case (in_prio)
      tlpjq_pkg::LVL_HIGH:   push_lv = tlpjq_pkg::LVL_HIGH;
      tlpjq_pkg::LVL_NORMAL: push_lv = tlpjq_pkg::LVL_NORMAL;
      default:               push_lv = tlpjq_pkg::LVL_LOW;
    endcase

    push_full = (cnt[push_lv] == CW'(QUEUE_DEPTH));
    tail_sum  = SW'(head[push_lv]) + SW'(cnt[push_lv]);
    if (tail_sum >= SW'(QUEUE_DEPTH)) begin
      tail_pos = PW'(tail_sum - SW'(QUEUE_DEPTH));
    end else begin
      tail_pos = PW'(tail_sum);
    end

    // strict priority under the ceiling; a ceiling of three acts as high
    take_hit = 1'b1;
    if (in_ceil >= tlpjq_pkg::LVL_HIGH && cnt[tlpjq_pkg::LVL_HIGH] != '0) begin
      take_lv = tlpjq_pkg::LVL_HIGH;
    end else if (in_ceil >= tlpjq_pkg::LVL_NORMAL && cnt[tlpjq_pkg::LVL_NORMAL] != '0) begin
      take_lv = tlpjq_pkg::LVL_NORMAL;
    end else if (cnt[tlpjq_pkg::LVL_LOW] != '0) begin
      take_lv = tlpjq_pkg::LVL_LOW;
    end else begin
      take_lv  = tlpjq_pkg::LVL_LOW;
      take_hit = 1'b0;
    end

    if (head[take_lv] == PW'(QUEUE_DEPTH - 1)) begin
      head_next = '0;
    end else begin
      head_next = head[take_lv] + PW'(1);
    end

    wr_en   = fire && is_push && !push_full;
    wr_addr = AW'(push_lv) * AW'(QUEUE_DEPTH) + AW'(tail_pos);
    rd_addr = AW'(take_lv) * AW'(QUEUE_DEPTH) + AW'(head[take_lv]);
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (fire) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_mode <= tlpjq_pkg::mode_t'(s_tuser[1:0]);
      in_job  <= s_tdata[7:0];
      in_prio <= s_tdata[9:8];
      in_ceil <= s_tdata[11:10];
    end
  end

  // head and count update
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < tlpjq_pkg::NUM_LEVELS; i++) begin
        head[i] <= '0;
        cnt[i]  <= '0;
      end
    end else if (fire) begin
      if (is_push && !push_full) begin
        cnt[push_lv] <= cnt[push_lv] + CW'(1);
      end else if (is_take && take_hit) begin
        head[take_lv] <= head_next;
        cnt[take_lv]  <= cnt[take_lv] - CW'(1);
      end
    end
  end

  // fifo storage: one write port for push, one registered read port for take
  always_ff @(posedge clk) begin
    if (wr_en) begin
      queue_mem[wr_addr] <= id;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && is_take && take_hit) begin
      job_rd <= queue_mem[rd_addr];
    end
  end

  // finished-job bitmap
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_idx  <= '0;
    end else if (clr_busy) begin
      clr_idx <= clr_idx + ID_BITS'(1);
      if (clr_idx == '1) begin
        clr_busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy) begin
      done_mem[clr_idx] <= 1'b0;
    end else if (fire && in_mode == tlpjq_pkg::MODE_FINISH) begin
      done_mem[id] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && in_mode == tlpjq_pkg::MODE_QUERY) begin
      fin_rd <= done_mem[id];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      o_qry   <= (in_mode == tlpjq_pkg::MODE_QUERY);
      o_hit   <= is_take && take_hit;
      o_level <= (is_take && take_hit) ? take_lv : tlpjq_pkg::LVL_LOW;
      if (is_push && push_full) begin
        o_status <= tlpjq_pkg::ST_FULL;
      end else if (is_take && !take_hit) begin
        o_status <= tlpjq_pkg::ST_EMPTY;
      end else begin
        o_status <= tlpjq_pkg::ST_OK;
      end
    end
  end

  // stored id shown on 8 bits
  assign job_wide = {8'h00, job_rd};

  assign m_tvalid      = out_valid;
  assign m_tdata[1:0]  = o_status;
  assign m_tdata[2]    = o_hit;
  assign m_tdata[10:3] = o_hit ? job_wide[7:0] : 8'h00;
  assign m_tdata[12:11] = o_level;
  assign m_tdata[13]   = o_qry & fin_rd;
  assign m_tdata[15:14] = 2'b00;

`ifndef SYNTHESIS
  // no item enters while the bitmap is being cleared
  assert property (@(posedge clk) disable iff (rst) clr_busy |-> !s_tready)
    else $error("item accepted during bitmap clear");

  // no fifo ever holds more than its depth
  assert property (@(posedge clk) disable iff (rst)
    cnt[tlpjq_pkg::LVL_LOW] <= CW'(QUEUE_DEPTH) &&
    cnt[tlpjq_pkg::LVL_NORMAL] <= CW'(QUEUE_DEPTH) &&
    cnt[tlpjq_pkg::LVL_HIGH] <= CW'(QUEUE_DEPTH))
    else $error("fifo count above depth");

  // a successful take from the high fifo lowers its count by one
  assert property (@(posedge clk) disable iff (rst)
    fire && is_take && take_hit && take_lv == tlpjq_pkg::LVL_HIGH |=>
    cnt[tlpjq_pkg::LVL_HIGH] == $past(cnt[tlpjq_pkg::LVL_HIGH]) - CW'(1))
    else $error("high fifo count not decremented on take");

  // a returned job always comes with an ok status
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && o_hit |-> o_status == tlpjq_pkg::ST_OK)
    else $error("job returned with bad status");
`endif

endmodule

`default_nettype wire

/* test/three_level_priority_job_queue_tb.sv */
`timescale 1ns / 100ps

module three_level_priority_job_queue_tb;

  localparam int unsigned FIFO_DEPTH = 16;

  // one result item, split into its fields
  typedef struct {
    tlpjq_pkg::status_t status;
    logic               job_valid;
    logic [7:0]         job_out;
    tlpjq_pkg::level_t  job_level;
    logic               is_finished;
  } job_result_t;

  // random stimulus runs in phases; fill and drain push the fifos toward full or empty
  typedef enum {
    PHASE_FILL,
    PHASE_DRAIN,
    PHASE_MIXED,
    PHASE_MARKS
  } phase_t;

  // tracks queue contents and the done bitmap, and holds awaited results
  class job_queue_scoreboard;
    logic [7:0]  slots [3][FIFO_DEPTH];
    int unsigned head [3];
    int unsigned fill [3];
    bit          done_ids [256];
    job_result_t awaited_results [$];
    int          mismatches;
    int          results_seen;

    task report_mismatch(string what);
      $display("[%0t] mismatch on result %0d: %s", $realtime, results_seen, what);
      mismatches++;
    endtask

    // an item was accepted: update the state and queue the result it causes
    function void note_item(tlpjq_pkg::mode_t op, logic [7:0] id, logic [1:0] prio,
                            logic [1:0] ceiling);
      job_result_t       r;
      tlpjq_pkg::level_t lvl;
      int                lv;
      bit                found;
      r.status      = tlpjq_pkg::ST_OK;
      r.job_valid   = 1'b0;
      r.job_out     = 8'd0;
      r.job_level   = tlpjq_pkg::LVL_LOW;
      r.is_finished = 1'b0;
      found         = 1'b0;
      case (op)
        tlpjq_pkg::MODE_PUSH: begin
          // unknown priority codes land in the low fifo
          if (prio == tlpjq_pkg::LVL_HIGH) lvl = tlpjq_pkg::LVL_HIGH;
          else if (prio == tlpjq_pkg::LVL_NORMAL) lvl = tlpjq_pkg::LVL_NORMAL;
          else lvl = tlpjq_pkg::LVL_LOW;
          if (fill[lvl] >= FIFO_DEPTH) begin
            r.status = tlpjq_pkg::ST_FULL;
          end else begin
            slots[lvl][(head[lvl] + fill[lvl]) % FIFO_DEPTH] = id;
            fill[lvl]++;
          end
        end
        tlpjq_pkg::MODE_TAKE: begin
          r.status = tlpjq_pkg::ST_EMPTY;
          // highest non-empty level at or below the ceiling wins
          for (lv = 2; lv >= 0; lv--) begin
            if (!found && lv <= int'(ceiling) && fill[lv] != 0) begin
              r.job_out   = slots[lv][head[lv]];
              head[lv]    = (head[lv] + 1) % FIFO_DEPTH;
              fill[lv]--;
              r.status    = tlpjq_pkg::ST_OK;
              r.job_valid = 1'b1;
              r.job_level = tlpjq_pkg::level_t'(lv);
              found       = 1'b1;
            end
          end
        end
        tlpjq_pkg::MODE_FINISH: done_ids[id] = 1'b1;
        default:                r.is_finished = done_ids[id];
      endcase
      awaited_results.push_back(r);
    endfunction

    task check_result(logic [15:0] word);
      job_result_t exp;
      results_seen++;
      if (awaited_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h", word));
      end else begin
        exp = awaited_results.pop_front();
        if (word[1:0] !== exp.status)
          report_mismatch($sformatf("status %0d, expected %0d", word[1:0], exp.status));
        if (word[2] !== exp.job_valid)
          report_mismatch($sformatf("job_valid %b, expected %b", word[2], exp.job_valid));
        if (word[10:3] !== exp.job_out)
          report_mismatch($sformatf("job_out %h, expected %h", word[10:3], exp.job_out));
        if (word[12:11] !== exp.job_level)
          report_mismatch($sformatf("job_level %0d, expected %0d",
                                    word[12:11], exp.job_level));
        if (word[13] !== exp.is_finished)
          report_mismatch($sformatf("is_finished %b, expected %b",
                                    word[13], exp.is_finished));
      end
    endtask

    function int pending();
      return awaited_results.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  // [7:0] job_id, [9:8] priority_req, [11:10] max_priority, [15:12] zero
  logic [15:0] s_tdata = 16'd0;
  // [1:0] mode
  logic [1:0]  s_tuser = 2'd0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  // [1:0] status, [2] job_valid, [10:3] job_out, [12:11] job_level,
  // [13] is_finished, [15:14] zero
  logic [15:0] m_tdata;

  job_queue_scoreboard sb = new();
  bit          quiet;          // no new idle gaps on either side while set
  int unsigned ready_hold;
  int          items_sent;

  three_level_priority_job_queue dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (quiet || roll < 55) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // offer one item, hold it until the block takes it
  task automatic send_item(tlpjq_pkg::mode_t op, logic [7:0] id, logic [1:0] prio,
                           logic [1:0] ceiling);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0000, ceiling, prio, id};
    s_tuser  <= op;
    do @(posedge clk); while (!s_tready);
    sb.note_item(op, id, prio, ceiling);
    items_sent++;
  endtask

  function automatic tlpjq_pkg::mode_t pick_op(phase_t kind);
    int unsigned roll;
    roll = $urandom_range(0, 9);
    case (kind)
      PHASE_FILL:
        return (roll < 8) ? tlpjq_pkg::MODE_PUSH :
               (roll == 8) ? tlpjq_pkg::MODE_TAKE : tlpjq_pkg::MODE_QUERY;
      PHASE_DRAIN:
        return (roll < 7) ? tlpjq_pkg::MODE_TAKE :
               (roll < 9) ? tlpjq_pkg::MODE_PUSH : tlpjq_pkg::MODE_FINISH;
      PHASE_MARKS:
        return (roll < 4) ? tlpjq_pkg::MODE_FINISH :
               (roll < 8) ? tlpjq_pkg::MODE_QUERY :
               (roll == 8) ? tlpjq_pkg::MODE_PUSH : tlpjq_pkg::MODE_TAKE;
      default:
        return tlpjq_pkg::mode_t'(2'($urandom_range(0, 3)));
    endcase
  endfunction

  // receiver: random stalls, none started while quiet
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (ready_hold != 0) begin
      ready_hold = ready_hold - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      if (!quiet && $urandom_range(0, 3) == 0) ready_hold = pick_gap();
    end
  end

  // every result item is checked against the oldest awaited one
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata);
  end

  initial begin
    phase_t           kind;
    int               len;
    tlpjq_pkg::mode_t op;
    logic [7:0]       id;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty reads, every level, unknown priorities, ceilings
    send_item(tlpjq_pkg::MODE_QUERY,  8'h00, 2'd0, 2'd0);
    send_item(tlpjq_pkg::MODE_QUERY,  8'hFF, 2'd0, 2'd0);
    send_item(tlpjq_pkg::MODE_TAKE,   8'h00, 2'd0, 2'd3);
    send_item(tlpjq_pkg::MODE_PUSH,   8'h00, 2'd0, 2'd0);
    send_item(tlpjq_pkg::MODE_PUSH,   8'hFF, 2'd1, 2'd0);
    send_item(tlpjq_pkg::MODE_PUSH,   8'hA5, 2'd2, 2'd0);
    send_item(tlpjq_pkg::MODE_PUSH,   8'h5A, 2'd3, 2'd0);   // unknown priority goes low
    send_item(tlpjq_pkg::MODE_TAKE,   8'h00, 2'd0, 2'd0);
    send_item(tlpjq_pkg::MODE_TAKE,   8'h00, 2'd0, 2'd1);
    send_item(tlpjq_pkg::MODE_TAKE,   8'h00, 2'd0, 2'd3);   // ceiling of three acts like high
    send_item(tlpjq_pkg::MODE_TAKE,   8'h00, 2'd0, 2'd2);
    send_item(tlpjq_pkg::MODE_TAKE,   8'h00, 2'd0, 2'd2);   // all empty now
    send_item(tlpjq_pkg::MODE_FINISH, 8'hFF, 2'd0, 2'd0);
    send_item(tlpjq_pkg::MODE_QUERY,  8'hFF, 2'd0, 2'd0);
    // finishing a queued job leaves it in its fifo
    send_item(tlpjq_pkg::MODE_PUSH,   8'h33, 2'd2, 2'd0);
    send_item(tlpjq_pkg::MODE_FINISH, 8'h33, 2'd0, 2'd0);
    send_item(tlpjq_pkg::MODE_TAKE,   8'h00, 2'd0, 2'd2);
    send_item(tlpjq_pkg::MODE_QUERY,  8'h33, 2'd0, 2'd0);
    // ceiling below the only waiting job gives empty
    send_item(tlpjq_pkg::MODE_PUSH,   8'h11, 2'd2, 2'd0);
    send_item(tlpjq_pkg::MODE_TAKE,   8'h00, 2'd0, 2'd0);
    send_item(tlpjq_pkg::MODE_TAKE,   8'h00, 2'd0, 2'd1);
    send_item(tlpjq_pkg::MODE_TAKE,   8'hC3, 2'd3, 2'd3);

    // random phases; fill phases run the fifos into full rejections
    while (items_sent < 820) begin
      kind  = phase_t'($urandom_range(0, 3));
      quiet = ($urandom_range(0, 3) == 0);
      len   = $urandom_range(20, 60);
      repeat (len) begin
        op = pick_op(kind);
        if ((op == tlpjq_pkg::MODE_FINISH || op == tlpjq_pkg::MODE_QUERY) &&
            $urandom_range(0, 9) < 7)
          id = 8'($urandom_range(0, 15));   // small pool so queries hit marked ids
        else
          id = 8'($urandom_range(0, 255));
        send_item(op, id, 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)));
      end
    end
    quiet = 1'b0;
    s_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.mismatches == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  // hang guard, far beyond the slowest correct run
  initial begin
    #10_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

/* sim.f */
rtl/core/tlpjq_pkg.sv
rtl/core/three_level_priority_job_queue.sv
test/three_level_priority_job_queue_tb.sv
